### rtl/core/hfd_pkg.sv
`default_nettype none
package hfd_pkg;

  localparam int CHARS_PER_FRAME = 32;
  localparam int WORD_SLOTS = 8;
  localparam int COUNT_W = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DIGIT_NINE = 8'd57;
  localparam logic [7:0] LETTER_BIAS = 8'd55;
  localparam logic [7:0] NIBBLE_BELOW = 8'd16;
  localparam logic [15:0] SCALE_RESET = 16'd60297;

  localparam logic [COUNT_W-1:0] FRAME_CHARS = COUNT_W'(CHARS_PER_FRAME);
  localparam logic [COUNT_W-1:0] WORD_LIMIT = COUNT_W'(4 * WORD_SLOTS);

  // one line end handed from the front to the back
  typedef struct packed {
    logic        good;
    logic [15:0] sum_x;
    logic [15:0] sum_y;
  } event_t;

  function automatic logic [7:0] nibble_of(input logic [7:0] b);
    logic [7:0] n;
    if (b < DIGIT_ZERO) begin
      n = NIBBLE_BELOW;
    end else if (b > DIGIT_NINE) begin
      n = b - LETTER_BIAS;
    end else begin
      n = b - DIGIT_ZERO;
    end
    return n;
  endfunction

  // signed divide by four, truncating toward zero
  function automatic logic [15:0] quarter_of(input logic [15:0] w);
    logic [15:0] t;
    t = w + {14'd0, w[15], w[15]};
    return {t[15], t[15], t[15:2]};
  endfunction

endpackage
`default_nettype wire

### rtl/core/hfd_front.sv
`default_nettype none
module hfd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  output logic                   ev_valid,
  output hfd_pkg::event_t        ev_data,
  input  wire logic              ev_ready
);

  logic [hfd_pkg::COUNT_W-1:0] char_count;
  logic [15:0] word_accum;
  logic [15:0] sum_x;
  logic [15:0] sum_y;

  logic        take;
  logic        is_newline;
  logic [15:0] acc_base;
  logic [15:0] word_new;
  logic [15:0] quarter;
  logic        word_done;
  logic        overlong;

  assign in_ready = ev_ready;
  assign take = in_valid && ev_ready;
  assign is_newline = (in_byte == hfd_pkg::NEWLINE_BYTE);

  assign acc_base = (char_count[1:0] == 2'd0) ? 16'd0 : word_accum;
  assign word_new = {acc_base[11:0], 4'd0} + {8'd0, hfd_pkg::nibble_of(in_byte)};
  assign quarter = hfd_pkg::quarter_of(word_new);
  assign word_done = (char_count[1:0] == 2'd3) && (char_count < hfd_pkg::WORD_LIMIT)
                     && (char_count < hfd_pkg::FRAME_CHARS);
  assign overlong = (char_count >= hfd_pkg::FRAME_CHARS);

  assign ev_valid = take && (is_newline || overlong);
  always_comb begin
    ev_data.good = is_newline && (char_count == hfd_pkg::FRAME_CHARS);
    ev_data.sum_x = sum_x;
    ev_data.sum_y = sum_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      word_accum <= '0;
      sum_x <= '0;
      sum_y <= '0;
    end else if (take) begin
      if (is_newline || overlong) begin
        char_count <= '0;
        word_accum <= '0;
        sum_x <= '0;
        sum_y <= '0;
      end else begin
        char_count <= char_count + 1'b1;
        word_accum <= word_new;
        // even word slots are x, odd are y
        if (word_done) begin
          if (char_count[2]) begin
            sum_y <= sum_y + quarter;
          end else begin
            sum_x <= sum_x + quarter;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/hfd_queue.sv
`default_nettype none
module hfd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire hfd_pkg::event_t   push_data,
  output logic                   not_full,
  input  wire logic              pop,
  output hfd_pkg::event_t        pop_data,
  output logic                   not_empty
);

  hfd_pkg::event_t entries [hfd_pkg::QUEUE_DEPTH];
  logic [hfd_pkg::QPTR_W-1:0] wr_ptr;
  logic [hfd_pkg::QPTR_W-1:0] rd_ptr;
  logic [hfd_pkg::QCNT_W-1:0] fill;

  assign not_full = (fill != hfd_pkg::QCNT_W'(hfd_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == hfd_pkg::QPTR_W'(hfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == hfd_pkg::QPTR_W'(hfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/hfd_back.sv
`default_nettype none
module hfd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              ev_valid,
  input  wire hfd_pkg::event_t   ev_data,
  output logic                   ev_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_ok,
  output logic [15:0]            out_avg_x,
  output logic [15:0]            out_avg_y,
  output logic [31:0]            out_flow_x,
  output logic [31:0]            out_flow_y,
  output logic [15:0]            out_errors
);

  logic [15:0] flow_scale;
  logic [15:0] last_avg_x;
  logic [15:0] last_avg_y;
  logic [15:0] bad_frames;

  logic [15:0] avg_x_next;
  logic [15:0] avg_y_next;
  logic [15:0] bad_frames_next;
  logic signed [16:0] neg_x;
  logic signed [16:0] neg_y;
  logic signed [16:0] scale_s;
  logic signed [33:0] prod_x;
  logic signed [33:0] prod_y;

  assign ev_pop = ev_valid && (!out_valid || out_ready);

  assign avg_x_next = ev_data.good ? ev_data.sum_x : last_avg_x;
  assign avg_y_next = ev_data.good ? ev_data.sum_y : last_avg_y;
  assign bad_frames_next = ev_data.good ? bad_frames : bad_frames + 1'b1;

  assign neg_x = -$signed({avg_x_next[15], avg_x_next});
  assign neg_y = -$signed({avg_y_next[15], avg_y_next});
  assign scale_s = $signed({1'b0, flow_scale});
  assign prod_x = neg_x * scale_s;
  assign prod_y = neg_y * scale_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_scale <= hfd_pkg::SCALE_RESET;
      last_avg_x <= '0;
      last_avg_y <= '0;
      bad_frames <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        flow_scale <= cfg_wdata;
      end
      if (ev_pop) begin
        last_avg_x <= avg_x_next;
        last_avg_y <= avg_y_next;
        bad_frames <= bad_frames_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      out_ok <= ev_data.good;
      out_avg_x <= avg_x_next;
      out_avg_y <= avg_y_next;
      out_flow_x <= prod_x[31:0];
      out_flow_y <= prod_y[31:0];
      out_errors <= bad_frames_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/hex_flow_line_decoder.sv
// Decodes a serial hex line from an optical flow sensor into x/y flow. A new byte on s_axis
// can be accepted in every cycle in which s_axis_tready is high; mid-line bytes give no
// result. A newline after exactly 32 characters ends a good line, an earlier newline or a
// 33rd character ends it as an error, and each line end gives one result on m_axis through a
// two-entry queue and an output register, which drives m_axis_tvalid. The front keeps taking
// bytes while a result waits; s_axis_tready drops only while both queue entries are held
// behind a stalled m_axis. The flow multiply by flow_scale sits in the back stage, one 17 by
// 17 product per axis. flow_scale (unsigned Q0.16, reset 60297) must be written through
// cfg_we/cfg_wdata only while no line end is in flight; the block itself does not enforce it.
`default_nettype none
module hex_flow_line_decoder (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // rx_byte
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [111:0]       m_axis_tdata,   // avg_x, avg_y, flow_x, flow_y, error_count
  output logic [0:0]         m_axis_tuser    // frame_ok
);

  logic            ev_valid;
  hfd_pkg::event_t ev_data;
  logic            q_not_full;
  logic            q_not_empty;
  logic            q_pop;
  hfd_pkg::event_t q_data;

  logic        ok;
  logic [15:0] avg_x;
  logic [15:0] avg_y;
  logic [31:0] flow_x;
  logic [31:0] flow_y;
  logic [15:0] errors;

  hfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .ev_valid (ev_valid),
    .ev_data  (ev_data),
    .ev_ready (q_not_full)
  );

  hfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_valid),
    .push_data (ev_data),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty)
  );

  hfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ev_valid   (q_not_empty),
    .ev_data    (q_data),
    .ev_pop     (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_ok     (ok),
    .out_avg_x  (avg_x),
    .out_avg_y  (avg_y),
    .out_flow_x (flow_x),
    .out_flow_y (flow_y),
    .out_errors (errors)
  );

  assign m_axis_tdata = {errors, flow_y, flow_x, avg_y, avg_x};
  assign m_axis_tuser = ok;

endmodule
`default_nettype wire

### verif/hex_flow_line_decoder_test.sv
`timescale 1ns / 1ps
module hex_flow_line_decoder_test;
  import hfd_pkg::*;

  localparam logic [7:0] LETTER_A = 8'h41;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PAUSE = 12;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic        ok;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [15:0] errs;
  } line_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  hex_flow_line_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // decoder state as the testbench sees it
  logic [15:0] scale_now = SCALE_RESET;
  logic [5:0] line_len = '0;
  logic [15:0] fold_word = '0;
  logic [15:0] line_words [WORD_SLOTS];
  logic [15:0] kept_avg_x = '0;
  logic [15:0] kept_avg_y = '0;
  logic [15:0] bad_lines = '0;

  logic [7:0] pending_bytes [$];
  line_result_t line_results_due [$];
  int mismatches = 0;
  int cycles = 0;
  int items_pushed = 0;
  int lines_pushed = 0;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  initial begin
    foreach (line_words[k]) line_words[k] = '0;
  end

  function automatic logic [31:0] scaled_flow(input logic [15:0] avg, input logic [15:0] sc);
    longint prod;
    prod = -longint'($signed(avg)) * longint'(sc);
    return prod[31:0];
  endfunction

  function automatic logic [15:0] axis_average(input int first);
    int sum;
    sum = 0;
    for (int k = first; k < WORD_SLOTS; k += 2) sum += int'($signed(line_words[k])) / 4;
    return sum[15:0];
  endfunction

  task automatic close_line(input bit good);
    line_result_t r;
    if (good) begin
      kept_avg_x = axis_average(0);
      kept_avg_y = axis_average(1);
    end else begin
      bad_lines = bad_lines + 16'd1;
    end
    r.ok = good;
    r.ax = kept_avg_x;
    r.ay = kept_avg_y;
    r.fx = scaled_flow(kept_avg_x, scale_now);
    r.fy = scaled_flow(kept_avg_y, scale_now);
    r.errs = bad_lines;
    line_results_due.push_back(r);
    line_len = '0;
    fold_word = '0;
    foreach (line_words[k]) line_words[k] = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0] nib;
    logic [5:0] pos;
    if (b == NEWLINE_BYTE) begin
      close_line(line_len == FRAME_CHARS);
      return;
    end
    pos = line_len;
    if (pos[1:0] == 2'd0) fold_word = '0;
    if (b < DIGIT_ZERO) nib = 8'd16;
    else if (b > DIGIT_NINE) nib = b - (LETTER_A - 8'd10);
    else nib = b - DIGIT_ZERO;
    fold_word = {fold_word[11:0], 4'h0} + {8'h00, nib};
    if (pos[1:0] == 2'd3 && (pos >> 2) < WORD_SLOTS && pos < FRAME_CHARS)
      line_words[pos[4:2]] = fold_word;
    line_len = pos + 6'd1;
    if (int'(pos) + 1 >= CHARS_PER_FRAME + 1) close_line(1'b0);
  endtask

  function automatic int draw_pause(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_PAUSE);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_bytes.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_bytes.pop_front();
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          gap_left <= draw_pause(send_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : receive_side
    line_result_t got;
    line_result_t want;
    int pause;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[63:32],
             m_axis_tdata[95:64], m_axis_tdata[111:96]};
      if (line_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: ok=%0b avg=%0d,%0d flow=%0d,%0d errors=%0d",
                   got.ok, $signed(got.ax), $signed(got.ay), $signed(got.fx),
                   $signed(got.fy), got.errs);
      end else begin
        want = line_results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch expected: ok=%0b avg=%0d,%0d flow=%0d,%0d errors=%0d",
                     want.ok, $signed(want.ax), $signed(want.ay), $signed(want.fx),
                     $signed(want.fy), want.errs);
            $display("           actual: ok=%0b avg=%0d,%0d flow=%0d,%0d errors=%0d",
                     got.ok, $signed(got.ax), $signed(got.ay), $signed(got.fx),
                     $signed(got.fy), got.errs);
          end
        end
      end
      if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
      pause = draw_pause(take_burst);
      stall_left <= pause;
      m_axis_tready <= (pause == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    items_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k]);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] v;
    if ($urandom_range(0, 15) < 13) begin
      v = 8'($urandom_range(0, 15));
      return (v < 10) ? DIGIT_ZERO + v : LETTER_A + v - 8'd10;
    end
    do v = 8'($urandom_range(0, 255)); while (v == NEWLINE_BYTE);
    return v;
  endfunction

  task automatic push_line(input int len);
    for (int k = 0; k < len; k++) push_byte(pick_char());
    push_byte(NEWLINE_BYTE);
    lines_pushed++;
  endtask

  task automatic run_random(input int item_goal, input int line_goal);
    int kind;
    int start_items;
    int start_lines;
    start_items = items_pushed;
    start_lines = lines_pushed;
    while (items_pushed - start_items < item_goal || lines_pushed - start_lines < line_goal) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        push_line(CHARS_PER_FRAME);
      end else if (kind == 7) begin
        push_line($urandom_range(0, CHARS_PER_FRAME - 1));
      end else if (kind == 8) begin
        // overlong line, sometimes with spill into the next one
        for (int k = 0; k < CHARS_PER_FRAME + 1 + $urandom_range(0, 3); k++)
          push_byte(pick_char());
        lines_pushed++;
      end else begin
        for (int k = 0; k < $urandom_range(1, 6); k++) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // hold the sender until the block has nothing in flight
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_axis_tvalid || line_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    scale_now = v;
    @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // newline alone, short line, then a good line with extreme words and odd characters
    push_byte(NEWLINE_BYTE);
    push_text("12");
    push_byte(NEWLINE_BYTE);
    push_text("80007FFFFFFDFFFC");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("/:00010000FFFF");
    push_byte(NEWLINE_BYTE);
    wait_idle();

    // largest averages against the largest scale
    write_scale(16'hFFFF);
    push_text("80007FFF80007FFF80007FFF80007FFF");
    push_byte(NEWLINE_BYTE);
    push_text("7FFF80007FFF80007FFF80007FFF8000");
    push_byte(NEWLINE_BYTE);
    push_byte(NEWLINE_BYTE);
    wait_idle();

    write_scale(16'h0000);
    run_random(150, 12);
    wait_idle();
    write_scale(16'h0001);
    run_random(150, 12);
    wait_idle();
    write_scale(16'($urandom_range(0, 65535)));
    run_random(150, 12);
    wait_idle();
    write_scale(SCALE_RESET);
    run_random(150, 12);
    wait_idle();

    if (mismatches == 0 && line_results_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
